/* hw/rtl/tmh_pkg.sv */
// Shared codes and types of the timer min-heap queue.
package tmh_pkg;

    // Input command codes
    typedef enum logic [2:0] {
        CMD_ADD    = 3'd0,
        CMD_DELETE = 3'd1,
        CMD_ADJUST = 3'd2,
        CMD_REHEAP = 3'd3,
        CMD_TICK   = 3'd4
    } cmd_t;

    // Result kind codes
    typedef enum logic [2:0] {
        KIND_ACK       = 3'd0,
        KIND_TERMINATE = 3'd1,
        KIND_STALE     = 3'd2,
        KIND_DONE      = 3'd3,
        KIND_REJECT    = 3'd4
    } kind_t;

    // Sequencer states, one-hot
    typedef enum logic [16:0] {
        S_IDLE    = 17'h00001,
        S_EMIT    = 17'h00002,
        S_UP_P    = 17'h00004,
        S_UP_H    = 17'h00008,
        S_UP_K    = 17'h00010,
        S_RH      = 17'h00020,
        S_DN_E    = 17'h00040,
        S_DN_EK   = 17'h00080,
        S_DN_L    = 17'h00100,
        S_DN_LH   = 17'h00200,
        S_DN_LK   = 17'h00400,
        S_DN_RH   = 17'h00800,
        S_DN_RK   = 17'h01000,
        S_DN_CMP  = 17'h02000,
        S_TK_ROOT = 17'h04000,
        S_TK_H    = 17'h08000,
        S_TK_K    = 17'h10000
    } state_t;

    // Fixed field widths
    localparam int ID_W   = 6;
    localparam int TIME_W = 32;
    localparam int DLY_W  = 16;

    // Expiry written by a lazy delete
    localparam logic [TIME_W-1:0] EXP_DELETED = 32'd1;

endpackage

/* hw/rtl/timer_min_heap_lazy_delete.sv */
// Timer queue kept as a binary min-heap of handles ordered by expiry time. One command is
// taken at a time while in_ready is high; delete, adjust, rejects and unknown commands go
// straight to their result. Add climbs one heap level per parent slot read, expiry read and
// compare; one tick pop reads the root and its expiry, then sifts down one level at a time,
// and reheap runs one such sift-down for each of count/2 slots. The pace is set by the
// single read port of the slot and expiry RAMs (each key costs a slot read then an expiry
// read) and by the one shared 32-bit comparator. Each result is held in an output register
// until taken; a tick gives one result per expired entry and then a done result.
module timer_min_heap_lazy_delete
    import tmh_pkg::*;
#(
    parameter int HEAP_DEPTH   = 32,
    parameter int HANDLE_COUNT = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [2:0]        command,
    input  logic [ID_W-1:0]   timer_id,
    input  logic [DLY_W-1:0]  delay,
    input  logic [TIME_W-1:0] now,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [2:0]        kind,
    output logic [ID_W-1:0]   handle,
    output logic [5:0]        heap_count,
    output logic              last
);

    localparam int AW    = $clog2(HEAP_DEPTH);
    localparam int PW    = AW + 2;
    localparam int CNT_W = $clog2(HEAP_DEPTH + 1);
    localparam int HW    = $clog2(HANDLE_COUNT);

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [PW-1:0]     pos_reg, pos_next;
    logic [PW-1:0]     cpos_reg, cpos_next;
    logic [ID_W-1:0]   h_reg, h_next;
    logic [ID_W-1:0]   ch_reg, ch_next;
    logic [TIME_W-1:0] key_reg, key_next;
    logic [TIME_W-1:0] ck_reg, ck_next;
    logic [TIME_W-1:0] now_reg, now_next;
    logic              tick_mode_reg, tick_mode_next;
    logic [2:0]        res_kind_reg, res_kind_next;
    logic [ID_W-1:0]   res_handle_reg, res_handle_next;
    logic              res_last_reg, res_last_next;
    logic              out_valid_reg, out_valid_next;
    logic [2:0]        kind_reg, kind_next;
    logic [ID_W-1:0]   handle_reg, handle_next;
    logic [5:0]        count_out_reg, count_out_next;
    logic              last_reg, last_next;
    logic [ID_W-1:0]   rh_reg;

    logic live_reg [HANDLE_COUNT];
    logic inheap_reg [HANDLE_COUNT];

    // RAM ports
    logic              heap_we;
    logic [AW-1:0]     heap_waddr, heap_raddr;
    logic [ID_W-1:0]   heap_wdata, heap_rdata;
    logic              exp_we;
    logic [HW-1:0]     exp_waddr, exp_raddr;
    logic [TIME_W-1:0] exp_wdata, exp_rdata;

    // Mark updates
    logic              mark_add, mark_kill, mark_pop;
    logic [HW-1:0]     mark_idx;

    // Shared comparator
    logic [TIME_W-1:0] cmp_a, cmp_b;
    logic              cmp_lt;

    logic [TIME_W:0]   exp_sum;
    logic [TIME_W-1:0] exp_new;
    logic [HW-1:0]     id_idx;
    logic              id_ok;
    logic              accept, out_free;
    logic [PW-1:0]     left_pos, right_pos, parent_pos, count_pw;

    tmh_ram #(.WIDTH(ID_W), .DEPTH(HEAP_DEPTH)) u_slot_ram (
        .clk   (clk),
        .we    (heap_we),
        .waddr (heap_waddr),
        .wdata (heap_wdata),
        .raddr (heap_raddr),
        .rdata (heap_rdata)
    );

    tmh_ram #(.WIDTH(TIME_W), .DEPTH(HANDLE_COUNT)) u_expiry_ram (
        .clk   (clk),
        .we    (exp_we),
        .waddr (exp_waddr),
        .wdata (exp_wdata),
        .raddr (exp_raddr),
        .rdata (exp_rdata)
    );

    assign in_ready   = (state_reg == S_IDLE);
    assign accept     = in_valid && in_ready;
    assign out_free   = !out_valid_reg || out_ready;
    assign out_valid  = out_valid_reg;
    assign kind       = kind_reg;
    assign handle     = handle_reg;
    assign heap_count = count_out_reg;
    assign last       = last_reg;

    // Saturating expiry and handle checks
    assign exp_sum  = {1'b0, now} + {{(TIME_W - DLY_W + 1){1'b0}}, delay};
    assign exp_new  = exp_sum[TIME_W] ? {TIME_W{1'b1}} : exp_sum[TIME_W-1:0];
    assign id_ok    = (32'(timer_id) < HANDLE_COUNT);
    assign id_idx   = HW'(timer_id);

    // Heap position arithmetic
    assign left_pos   = {pos_reg[PW-2:0], 1'b1};
    assign right_pos  = left_pos + PW'(1);
    assign parent_pos = (pos_reg - PW'(1)) >> 1;
    assign count_pw   = PW'(count_reg);

    // Comparator operand select
    always_comb
    begin
        cmp_a = key_reg;
        cmp_b = exp_rdata;
        case (state_reg)
            S_DN_RK:
            begin
                cmp_a = exp_rdata;
                cmp_b = ck_reg;
            end
            S_DN_CMP:
            begin
                cmp_a = ck_reg;
                cmp_b = key_reg;
            end
            S_TK_K:
            begin
                cmp_a = now_reg;
                cmp_b = exp_rdata;
            end
            default:
            begin
                cmp_a = key_reg;
                cmp_b = exp_rdata;
            end
        endcase
    end

    assign cmp_lt = (cmp_a < cmp_b);

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        pos_next        = pos_reg;
        cpos_next       = cpos_reg;
        h_next          = h_reg;
        ch_next         = ch_reg;
        key_next        = key_reg;
        ck_next         = ck_reg;
        now_next        = now_reg;
        tick_mode_next  = tick_mode_reg;
        res_kind_next   = res_kind_reg;
        res_handle_next = res_handle_reg;
        res_last_next   = res_last_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        kind_next       = kind_reg;
        handle_next     = handle_reg;
        count_out_next  = count_out_reg;
        last_next       = last_reg;
        heap_we         = 1'b0;
        heap_waddr      = pos_reg[AW-1:0];
        heap_wdata      = h_reg;
        heap_raddr      = pos_reg[AW-1:0];
        exp_we          = 1'b0;
        exp_waddr       = id_idx;
        exp_wdata       = exp_new;
        exp_raddr       = HW'(ch_reg);
        mark_add        = 1'b0;
        mark_kill       = 1'b0;
        mark_pop        = 1'b0;
        mark_idx        = id_idx;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    now_next        = now;
                    res_handle_next = timer_id;
                    res_last_next   = 1'b1;
                    res_kind_next   = KIND_REJECT;
                    state_next      = S_EMIT;
                    case (command)
                        CMD_ADD:
                        begin
                            if (id_ok && !inheap_reg[id_idx] &&
                                (32'(count_reg) < HEAP_DEPTH))
                            begin
                                exp_we        = 1'b1;
                                mark_add      = 1'b1;
                                key_next      = exp_new;
                                h_next        = timer_id;
                                pos_next      = count_pw;
                                count_next    = count_reg + CNT_W'(1);
                                res_kind_next = KIND_ACK;
                                state_next    = S_UP_P;
                            end
                        end
                        CMD_DELETE:
                        begin
                            if (id_ok && inheap_reg[id_idx])
                            begin
                                exp_we        = 1'b1;
                                exp_wdata     = EXP_DELETED;
                                mark_kill     = 1'b1;
                                res_kind_next = KIND_ACK;
                            end
                        end
                        CMD_ADJUST:
                        begin
                            if (id_ok && inheap_reg[id_idx])
                            begin
                                exp_we        = 1'b1;
                                res_kind_next = KIND_ACK;
                            end
                        end
                        CMD_REHEAP:
                        begin
                            tick_mode_next  = 1'b0;
                            idx_next        = count_reg >> 1;
                            res_kind_next   = KIND_ACK;
                            res_handle_next = '0;
                            state_next      = S_RH;
                        end
                        CMD_TICK:
                        begin
                            tick_mode_next = 1'b1;
                            state_next     = S_TK_ROOT;
                        end
                        default:
                        begin
                            res_handle_next = '0;
                        end
                    endcase
                end
            end

            // Deliver one result to the output register
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = res_kind_reg;
                    handle_next    = res_handle_reg;
                    count_out_next = 6'(count_reg);
                    last_next      = res_last_reg;
                    state_next     = res_last_reg ? S_IDLE : S_TK_ROOT;
                end
            end

            // Sift up: fetch parent slot
            S_UP_P:
            begin
                if (pos_reg == '0)
                begin
                    heap_we    = 1'b1;
                    state_next = S_EMIT;
                end
                else
                begin
                    heap_raddr = parent_pos[AW-1:0];
                    state_next = S_UP_H;
                end
            end
            S_UP_H:
            begin
                ch_next    = heap_rdata;
                exp_raddr  = HW'(heap_rdata);
                state_next = S_UP_K;
            end
            S_UP_K:
            begin
                heap_we = 1'b1;
                if (cmp_lt)
                begin
                    heap_wdata = ch_reg;
                    pos_next   = parent_pos;
                    state_next = S_UP_P;
                end
                else
                begin
                    state_next = S_EMIT;
                end
            end

            // Reheap: next slot to sift down
            S_RH:
            begin
                if (idx_reg == '0)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    idx_next   = idx_reg - CNT_W'(1);
                    pos_next   = PW'(idx_reg - CNT_W'(1));
                    heap_raddr = AW'(idx_reg - CNT_W'(1));
                    state_next = S_DN_E;
                end
            end

            // Sift down: load moving entry and its key
            S_DN_E:
            begin
                h_next     = heap_rdata;
                exp_raddr  = HW'(heap_rdata);
                state_next = S_DN_EK;
            end
            S_DN_EK:
            begin
                key_next   = exp_rdata;
                state_next = S_DN_L;
            end
            S_DN_L:
            begin
                if (left_pos >= count_pw)
                begin
                    heap_we    = 1'b1;
                    state_next = tick_mode_reg ? S_EMIT : S_RH;
                end
                else
                begin
                    heap_raddr = left_pos[AW-1:0];
                    state_next = S_DN_LH;
                end
            end
            S_DN_LH:
            begin
                ch_next    = heap_rdata;
                exp_raddr  = HW'(heap_rdata);
                state_next = S_DN_LK;
            end
            S_DN_LK:
            begin
                ck_next   = exp_rdata;
                cpos_next = left_pos;
                if (right_pos < count_pw)
                begin
                    heap_raddr = right_pos[AW-1:0];
                    state_next = S_DN_RH;
                end
                else
                begin
                    state_next = S_DN_CMP;
                end
            end
            S_DN_RH:
            begin
                res_handle_next = res_handle_reg;
                h_next          = h_reg;
                exp_raddr       = HW'(heap_rdata);
                cpos_next       = right_pos;
                // Right child handle is parked in rh_reg until its key arrives
                ch_next         = ch_reg;
                key_next        = key_reg;
                idx_next        = idx_reg;
                state_next      = S_DN_RK;
            end
            S_DN_RK:
            begin
                // Right child wins only when strictly smaller
                if (cmp_lt)
                begin
                    ck_next = exp_rdata;
                    ch_next = rh_reg;
                end
                else
                begin
                    cpos_next = left_pos;
                end
                state_next = S_DN_CMP;
            end
            S_DN_CMP:
            begin
                heap_we = 1'b1;
                if (cmp_lt)
                begin
                    heap_wdata = ch_reg;
                    pos_next   = cpos_reg;
                    state_next = S_DN_L;
                end
                else
                begin
                    state_next = tick_mode_reg ? S_EMIT : S_RH;
                end
            end

            // Tick: inspect the root
            S_TK_ROOT:
            begin
                res_last_next   = 1'b1;
                res_kind_next   = KIND_DONE;
                res_handle_next = '0;
                if (count_reg == '0)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    heap_raddr = '0;
                    state_next = S_TK_H;
                end
            end
            S_TK_H:
            begin
                ch_next    = heap_rdata;
                exp_raddr  = HW'(heap_rdata);
                state_next = S_TK_K;
            end
            S_TK_K:
            begin
                if (cmp_lt)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    // Pop root, move the last slot up and sift it down
                    mark_pop        = 1'b1;
                    mark_idx        = HW'(ch_reg);
                    res_kind_next   = live_reg[HW'(ch_reg)] ? KIND_TERMINATE : KIND_STALE;
                    res_handle_next = ch_reg;
                    res_last_next   = 1'b0;
                    count_next      = count_reg - CNT_W'(1);
                    heap_raddr      = AW'(count_reg - CNT_W'(1));
                    pos_next        = '0;
                    state_next      = S_DN_E;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // The right child handle arrives on the slot RAM in the cycle before its key arrives
    always_ff @(posedge clk)
    begin
        if (state_reg == S_DN_RH)
        begin
            rh_reg <= heap_rdata;
        end
    end

    // Control and payload registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            tick_mode_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            tick_mode_reg <= tick_mode_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        pos_reg        <= pos_next;
        cpos_reg       <= cpos_next;
        h_reg          <= h_next;
        ch_reg         <= ch_next;
        key_reg        <= key_next;
        ck_reg         <= ck_next;
        now_reg        <= now_next;
        res_kind_reg   <= res_kind_next;
        res_handle_reg <= res_handle_next;
        res_last_reg   <= res_last_next;
        kind_reg       <= kind_next;
        handle_reg     <= handle_next;
        count_out_reg  <= count_out_next;
        last_reg       <= last_next;
    end

    // Live and in-heap marks
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < HANDLE_COUNT; i++)
            begin
                live_reg[i]   <= 1'b0;
                inheap_reg[i] <= 1'b0;
            end
        end
        else if (mark_add)
        begin
            live_reg[mark_idx]   <= 1'b1;
            inheap_reg[mark_idx] <= 1'b1;
        end
        else if (mark_kill)
        begin
            live_reg[mark_idx] <= 1'b0;
        end
        else if (mark_pop)
        begin
            live_reg[mark_idx]   <= 1'b0;
            inheap_reg[mark_idx] <= 1'b0;
        end
    end

endmodule

/* hw/rtl/tmh_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module tmh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
